// File: src/greedy_first_fit_matcher_defines.svh
// Assertion macros used by the greedy first-fit matcher RTL.
`ifndef GREEDY_FIRST_FIT_MATCHER_DEFINES_SVH
`define GREEDY_FIRST_FIT_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, disabled while reset is asserted.
`define GFFM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("gffm assertion failed");
// Checked on every rising clock edge, also during reset.
`define GFFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("gffm assertion failed");
`else
`define GFFM_ASSERT(lbl, clk, rstn, prop)
`define GFFM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: src/gffm_pkg.sv
// Types and constants of the greedy first-fit matcher.
package gffm_pkg;

  localparam int unsigned IdxW  = 9;
  localparam int unsigned TypeW = 2;

  typedef logic [TypeW-1:0] req_type_t;

  localparam req_type_t ReqCand  = 2'd0;
  localparam req_type_t ReqClose = 2'd1;
  localparam req_type_t ReqEnd   = 2'd2;

  typedef enum logic [1:0] {
    KindGrant     = 2'd0,
    KindUnmatched = 2'd1,
    KindOptimal   = 2'd2,
    KindImprove   = 2'd3
  } result_kind_e;

  typedef struct packed {
    req_type_t       req_type;
    logic [IdxW-1:0] resource_index;
  } gffm_req_t;

  typedef struct packed {
    result_kind_e    result_kind;
    logic [IdxW-1:0] requester;
    logic [IdxW-1:0] resource;
  } gffm_res_t;

endpackage

// File: src/greedy_first_fit_matcher.sv
// Top level of the greedy first-fit matcher.
//
//   Channel   Direction  Handshake                Payload
//   in        input      in_valid_i / in_ready_o  in_req_i (gffm_req_t)
//   out       output     out_valid_o/out_ready_i  out_res_o (gffm_res_t)
//   cfg       input      cfg_valid_i/cfg_ready_o  cfg_data_i (num_resources)
//
// One request is taken every cycle unless a full result register stalls it.
// The free-map update and lowest-free encoder are combinational; results are registered.
// Reset clears the resource map and round counters at once; num_resources resets to 256.
// A request that gives a result waits only while the result register is full.
module greedy_first_fit_matcher #(
  parameter int unsigned MAX_RESOURCES = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gffm_pkg::gffm_req_t       in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gffm_pkg::gffm_res_t       out_res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gffm_pkg::IdxW-1:0] cfg_data_i
);
  import gffm_pkg::*;

  logic [IdxW-1:0] num_res_q;
  logic            item_valid;
  gffm_req_t       item;
  logic            item_take;
  logic            slot_free;
  logic            res_load;
  gffm_res_t       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_res_q <= IdxW'(256);
    end else if (cfg_valid_i) begin
      num_res_q <= cfg_data_i;
    end
  end

  gffm_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  gffm_core #(
    .MAX_RESOURCES (MAX_RESOURCES)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .num_resources_i (num_res_q),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_take_o     (item_take),
    .slot_free_i     (slot_free),
    .res_load_o      (res_load),
    .res_o           (res)
  );

  gffm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_load_i  (res_load),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

// File: src/gffm_in_stage.sv
// Input register that holds one request until the matching core takes it.
module gffm_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gffm_pkg::gffm_req_t in_req_i,
  output logic               item_valid_o,
  output gffm_pkg::gffm_req_t item_o,
  input  logic               item_take_i
);
  import gffm_pkg::*;

  logic      valid_q, valid_d;
  gffm_req_t req_q;

  assign in_ready_o   = !valid_q || item_take_i;
  assign valid_d      = in_ready_o ? in_valid_i : valid_q;
  assign item_valid_o = valid_q;
  assign item_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

endmodule

// File: src/gffm_core.sv
// Matching state and the combinational decision for one request.
`include "greedy_first_fit_matcher_defines.svh"

module gffm_core #(
  parameter int unsigned MAX_RESOURCES = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gffm_pkg::IdxW-1:0] num_resources_i,
  input  logic                      item_valid_i,
  input  gffm_pkg::gffm_req_t       item_i,
  output logic                      item_take_o,
  input  logic                      slot_free_i,
  output logic                      res_load_o,
  output gffm_pkg::gffm_res_t       res_o
);
  import gffm_pkg::*;

  localparam int unsigned IdxMax   = (1 << IdxW) - 1;
  localparam int unsigned MapDepth = (MAX_RESOURCES < IdxMax) ? MAX_RESOURCES : IdxMax;
  localparam int unsigned MapW     = (MapDepth > 1) ? $clog2(MapDepth) : 1;

  logic [MapDepth-1:0] used_q, used_d;
  logic [IdxW-1:0]     best_q, best_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     unm_q, unm_d;

  logic [IdxW-1:0] n_eff;
  logic [IdxW-1:0] cand;
  logic [IdxW-1:0] next_cnt;
  logic [IdxW-1:0] free_res;
  logic [MapW-1:0] cand_idx;
  logic [MapW-1:0] pick_idx;
  logic            cand_ok;
  logic            pick_ok;
  logic            full;
  logic            res_valid;

  assign n_eff    = (num_resources_i < IdxW'(MapDepth)) ? num_resources_i : IdxW'(MapDepth);
  assign cand     = item_i.resource_index;
  assign cand_idx = MapW'(cand - IdxW'(1));
  assign pick_idx = MapW'(best_q - IdxW'(1));
  assign next_cnt = cnt_q + IdxW'(1);
  assign full     = (cnt_q >= n_eff);

  assign cand_ok = (cand != '0) && (cand <= n_eff) && !used_q[cand_idx] &&
                   ((best_q == '0) || (cand < best_q));
  assign pick_ok = (best_q != '0) && (best_q <= n_eff) && !used_q[pick_idx];

  // Lowest free resource within the active count; zero when all are used.
  always_comb begin
    free_res = '0;
    for (int i = MapDepth - 1; i >= 0; i--) begin
      if (!used_q[i] && (IdxW'(i) < n_eff)) begin
        free_res = IdxW'(i + 1);
      end
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res_o     = '{result_kind: KindOptimal, requester: '0, resource: '0};
    used_d    = used_q;
    best_d    = best_q;
    cnt_d     = cnt_q;
    unm_d     = unm_q;
    case (item_i.req_type)
      ReqCand: begin
        if (cand_ok) begin
          best_d = cand;
        end
      end
      ReqClose: begin
        best_d = '0;
        if (!full) begin
          res_valid       = 1'b1;
          cnt_d           = next_cnt;
          res_o.requester = next_cnt;
          if (pick_ok) begin
            used_d[pick_idx]  = 1'b1;
            res_o.result_kind = KindGrant;
            res_o.resource    = best_q;
          end else begin
            res_o.result_kind = KindUnmatched;
            if (unm_q == '0) begin
              unm_d = next_cnt;
            end
          end
        end
      end
      ReqEnd: begin
        res_valid = 1'b1;
        if ((unm_q != '0) && (free_res != '0)) begin
          res_o.result_kind = KindImprove;
          res_o.requester   = unm_q;
          res_o.resource    = free_res;
        end
        used_d = '0;
        best_d = '0;
        cnt_d  = '0;
        unm_d  = '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign item_take_o = item_valid_i && (!res_valid || slot_free_i);
  assign res_load_o  = item_take_o && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      best_q <= '0;
      cnt_q  <= '0;
      unm_q  <= '0;
    end else if (item_take_o) begin
      used_q <= used_d;
      best_q <= best_d;
      cnt_q  <= cnt_d;
      unm_q  <= unm_d;
    end
  end

  `GFFM_ASSERT(a_round_clears, clk_i, rst_ni,
               (item_take_o && item_i.req_type == ReqEnd) |=>
               (cnt_q == '0 && unm_q == '0 && best_q == '0 && used_q == '0))
  `GFFM_ASSERT(a_grant_nonzero, clk_i, rst_ni,
               (res_load_o && res_o.result_kind == KindGrant) |->
               (res_o.resource != '0 && res_o.requester != '0))
  `GFFM_ASSERT(a_unmatched_seen, clk_i, rst_ni, (unm_q != '0) |-> (unm_q <= cnt_q))
  `GFFM_ASSERT_ALWAYS(a_load_needs_slot, clk_i, res_load_o |-> slot_free_i)

endmodule

// File: src/gffm_out_stage.sv
// Result register that holds one result until the consumer takes it.
module gffm_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_load_i,
  input  gffm_pkg::gffm_res_t res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gffm_pkg::gffm_res_t out_res_o
);
  import gffm_pkg::*;

  logic      valid_q, valid_d;
  gffm_res_t res_q;

  assign slot_free_o = !valid_q || out_ready_i;
  assign valid_d     = slot_free_o ? res_load_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the greedy first-fit matcher.
`timescale 1ns / 1ps

module tb_top;
  import gffm_pkg::*;

  localparam req_type_t ReqUnknown = 2'd3;
  localparam int unsigned IdxMax = 511;
  localparam int unsigned MapSize = 256;
  localparam int unsigned ResultLatency = 4;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomItems = 860;

  bit clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  gffm_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  gffm_res_t out_res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IdxW-1:0] cfg_data_i = '0;

  bit taken_map [1:MapSize];
  int unsigned resource_limit = 256;
  int unsigned best_cand;
  int unsigned closed_cnt;
  int unsigned first_miss;

  gffm_res_t pending_results [$];
  int unsigned failures;
  int unsigned requests_sent;
  int unsigned rounds_ended;
  int unsigned limits_written;
  int unsigned kind_seen [4];

  int unsigned burst_left;
  bit hold_off_req;
  int unsigned hold_left;
  int unsigned rx_mode;
  int unsigned rx_seg_left;

  greedy_first_fit_matcher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic clear_round_state();
    foreach (taken_map[i]) taken_map[i] = 1'b0;
    best_cand = 0;
    closed_cnt = 0;
    first_miss = 0;
  endtask

  task automatic predict_match(input gffm_req_t r, output bit has_res, output gffm_res_t res);
    int unsigned n;
    int unsigned pick;
    int unsigned lowest_free;
    n = (resource_limit < MapSize) ? resource_limit : MapSize;
    has_res = 1'b0;
    res = '0;
    case (r.req_type)
      ReqCand: begin
        if (r.resource_index >= 1 && r.resource_index <= n && !taken_map[r.resource_index] &&
            (best_cand == 0 || r.resource_index < best_cand))
          best_cand = 32'(r.resource_index);
      end
      ReqClose: begin
        pick = best_cand;
        best_cand = 0;
        if (closed_cnt < n) begin
          closed_cnt++;
          has_res = 1'b1;
          res.requester = IdxW'(closed_cnt);
          if (pick >= 1 && pick <= n && !taken_map[pick]) begin
            taken_map[pick] = 1'b1;
            res.result_kind = KindGrant;
            res.resource = IdxW'(pick);
          end else begin
            if (first_miss == 0) first_miss = closed_cnt;
            res.result_kind = KindUnmatched;
          end
        end
      end
      ReqEnd: begin
        lowest_free = 0;
        for (int i = n; i >= 1; i--) begin
          if (!taken_map[i]) lowest_free = i;
        end
        has_res = 1'b1;
        if (first_miss == 0 || lowest_free == 0) begin
          res.result_kind = KindOptimal;
        end else begin
          res.result_kind = KindImprove;
          res.requester = IdxW'(first_miss);
          res.resource = IdxW'(lowest_free);
        end
        clear_round_state();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    bit has_res;
    gffm_res_t res;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_match(in_req_i, has_res, res);
      if (has_res) pending_results.insert(pending_results.size(), res);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) resource_limit = 32'(cfg_data_i);
  end

  always @(posedge clk_i) begin
    gffm_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      kind_seen[out_res_o.result_kind]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d requester %0d resource %0d",
               out_res_o.result_kind, out_res_o.requester, out_res_o.resource);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res_o.result_kind !== exp_res.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", exp_res.result_kind,
                 out_res_o.result_kind);
          failures++;
        end
        if (out_res_o.requester !== exp_res.requester) begin
          $error("requester: expected %0d, actual %0d", exp_res.requester,
                 out_res_o.requester);
          failures++;
        end
        if (out_res_o.resource !== exp_res.resource) begin
          $error("resource: expected %0d, actual %0d", exp_res.resource, out_res_o.resource);
          failures++;
        end
      end
    end
  end

  // The result side stalls in segments of random mode and length, and on request holds off
  // for a long stretch so that the block backs up into its request side.
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_left = HoldOffCycles;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_seg_left = $urandom_range(5, 60);
      end
      rx_seg_left--;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic send_req(input req_type_t kind, input int unsigned idx);
    in_valid_i <= 1'b1;
    in_req_i <= '{req_type: kind, resource_index: idx[IdxW-1:0]};
    do @(posedge clk_i); while (!in_ready_o);
    if (kind != ReqUnknown) requests_sent++;
    if (kind == ReqEnd) rounds_ended++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ResultLatency) @(posedge clk_i);
  endtask

  task automatic write_resource_limit(input int unsigned value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[IdxW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limits_written++;
    @(posedge clk_i);
  endtask

  task automatic test_edge_candidates();
    write_resource_limit(256);
    send_req(ReqCand, 0);
    send_req(ReqCand, 257);
    send_req(ReqCand, IdxMax);
    send_req(ReqCand, 256);
    send_req(ReqCand, 1);
    send_req(ReqCand, 1);
    send_req(ReqClose, 0);
    send_req(ReqCand, 1);
    send_req(ReqClose, IdxMax);
    send_req(ReqClose, 0);
    send_req(ReqUnknown, IdxMax);
    send_req(ReqEnd, IdxMax);
  endtask

  task automatic test_limit_extremes();
    write_resource_limit(1);
    send_req(ReqCand, 1);
    send_req(ReqClose, 0);
    send_req(ReqCand, 1);
    send_req(ReqClose, 0);
    send_req(ReqEnd, 0);
    write_resource_limit(0);
    send_req(ReqCand, 1);
    send_req(ReqClose, 0);
    send_req(ReqEnd, 0);
    write_resource_limit(IdxMax);
    send_req(ReqCand, 256);
    send_req(ReqClose, 0);
    send_req(ReqEnd, 0);
  endtask

  task automatic test_limit_change_mid_round();
    write_resource_limit(4);
    send_req(ReqCand, 1);
    send_req(ReqClose, 0);
    send_req(ReqClose, 0);
    write_resource_limit(2);
    send_req(ReqCand, 2);
    send_req(ReqClose, 0);
    send_req(ReqEnd, 0);
  endtask

  task automatic test_output_hold_off();
    write_resource_limit(256);
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_req(ReqCand, $urandom_range(1, 256));
      send_req(ReqClose, 0);
    end
    send_req(ReqEnd, 0);
  endtask

  task automatic test_full_round();
    write_resource_limit(256);
    for (int i = 1; i <= 256; i++) begin
      if ($urandom_range(0, 3) == 0) send_req(ReqCand, $urandom_range(i, 256));
      send_req(ReqCand, i);
      send_req(ReqClose, 0);
    end
    send_req(ReqClose, 0);
    send_req(ReqEnd, 0);
  endtask

  task automatic test_random_rounds();
    int unsigned n;
    int unsigned eff;
    int unsigned requesters;
    int unsigned cands;
    int unsigned pick;
    int unsigned start_count;
    start_count = requests_sent;
    while (requests_sent - start_count < RandomItems) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) n = $urandom_range(1, 12);
        else if (pick < 15) n = $urandom_range(13, 255);
        else if (pick < 16) n = 256;
        else if (pick < 17) n = 0;
        else if (pick < 18) n = $urandom_range(257, IdxMax);
        else n = 1;
        write_resource_limit(n);
      end
      eff = (resource_limit < MapSize) ? resource_limit : MapSize;
      requesters = (eff < 16) ? $urandom_range(0, eff + 2) : $urandom_range(0, 18);
      for (int r = 0; r < requesters; r++) begin
        cands = $urandom_range(0, 4);
        for (int c = 0; c < cands; c++) begin
          if (eff > 0 && $urandom_range(0, 6) != 0) send_req(ReqCand, $urandom_range(1, eff));
          else send_req(ReqCand, $urandom_range(0, IdxMax));
          if ($urandom_range(0, 30) == 0) send_req(ReqUnknown, $urandom_range(0, IdxMax));
        end
        send_req(ReqClose, $urandom_range(0, IdxMax));
      end
      send_req(ReqEnd, $urandom_range(0, IdxMax));
    end
  endtask

  initial begin
    clear_round_state();
    burst_left = $urandom_range(1, 12);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_candidates();
    test_limit_extremes();
    test_limit_change_mid_round();
    test_output_hold_off();
    test_full_round();
    test_random_rounds();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      failures++;
    end
    $display("Sent %0d requests over %0d rounds with %0d limit writes.", requests_sent,
             rounds_ended, limits_written);
    $display("Results seen: %0d grants, %0d unmatched, %0d optimal, %0d improve.",
             kind_seen[KindGrant], kind_seen[KindUnmatched], kind_seen[KindOptimal],
             kind_seen[KindImprove]);
    if (failures == 0) begin
      $display("greedy_first_fit_matcher: match");
    end else begin
      $display("greedy_first_fit_matcher: mismatch");
    end
    $finish;
  end

  initial begin
    #3_600_000;
    $display("greedy_first_fit_matcher: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/gffm_pkg.sv
src/gffm_in_stage.sv
src/gffm_core.sv
src/gffm_out_stage.sv
src/greedy_first_fit_matcher.sv
test/tb_top.sv
